// ===== hdl/csim_pkg.sv =====
`timescale 1ns / 1ps

package csim_pkg;

  localparam int ACC_W  = 48;
  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * ACC_W;
  localparam int DVD_W  = ACC_W + DATA_W - 1;
  localparam int CNT_W  = 6;

  localparam logic [ACC_W-1:0] NORM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] DOT_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] DOT_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [DATA_W-1:0] SIM_MAX = 16'h7fff;
  localparam logic [DATA_W-1:0] SIM_MIN = 16'h8000;

  localparam logic [CNT_W-1:0] MUL_LAST   = 6'd3;
  localparam logic [CNT_W-1:0] SQRT_FIRST = 6'd47;
  localparam logic [CNT_W-1:0] DIV_FIRST  = 6'd62;

  typedef enum logic {
    ST_ACC,
    ST_CALC
  } top_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_SQRT,
    CS_DIV,
    CS_FIN,
    CS_DONE
  } calc_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } calc_ctl_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] sim;
  } calc_sts_t;

endpackage

// ===== hdl/csim_calc.sv =====
`timescale 1ns / 1ps

module csim_calc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csim_pkg::calc_ctl_t               ctl,
  input  logic        [csim_pkg::ACC_W-1:0] norm_a,
  input  logic        [csim_pkg::ACC_W-1:0] norm_b,
  input  logic signed [csim_pkg::ACC_W-1:0] dot,
  output csim_pkg::calc_sts_t               sts
);
  import csim_pkg::*;

  calc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W+15:0] pp_r, pp_nxt;
  logic [49:0]       rem_r, rem_nxt;
  logic [ACC_W-1:0]  root_r, root_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [15:0]       q_r, q_nxt;
  logic              ovf_r, ovf_nxt;
  logic              neg_r, neg_nxt;
  logic [15:0]       sim_r, sim_nxt;

  logic [15:0]       b_chunk;
  logic [PROD_W-1:0] pp_sh;
  logic [51:0]       sub_a, sub_b;
  logic [52:0]       diff;
  logic              ge;
  logic [ACC_W-1:0]  mag;

  // shared compare-subtract for root and quotient steps
  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[52];
  assign mag  = dot[ACC_W-1] ? ACC_W'(-dot) : ACC_W'(dot);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    b_chunk = norm_b[15:0];
      2'd1:    b_chunk = norm_b[31:16];
      default: b_chunk = norm_b[47:32];
    endcase
    case (cnt_r[1:0])
      2'd1:    pp_sh = {32'b0, pp_r};
      2'd2:    pp_sh = {16'b0, pp_r, 16'b0};
      2'd3:    pp_sh = {pp_r, 32'b0};
      default: pp_sh = '0;
    endcase
    if (state_r == CS_SQRT) begin
      sub_a = {rem_r, prod_r[PROD_W-1:PROD_W-2]};
      sub_b = {2'b0, root_r, 2'b01};
    end else begin
      sub_a = {3'b0, rem_r[ACC_W-1:0], dvd_r[DVD_W-1]};
      sub_b = {4'b0, root_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    pp_r   <= pp_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dvd_r  <= dvd_nxt;
    q_r    <= q_nxt;
    ovf_r  <= ovf_nxt;
    neg_r  <= neg_nxt;
    sim_r  <= sim_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    pp_nxt    = pp_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    dvd_nxt   = dvd_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    neg_nxt   = neg_r;
    sim_nxt   = sim_r;
    unique case (state_r)
      CS_IDLE: begin
        if (ctl.start) begin
          state_nxt = CS_MUL;
          cnt_nxt   = '0;
          prod_nxt  = '0;
        end
      end
      CS_MUL: begin
        pp_nxt   = norm_a * b_chunk;
        prod_nxt = prod_r + pp_sh;
        if (cnt_r == MUL_LAST) begin
          state_nxt = CS_SQRT;
          cnt_nxt   = SQRT_FIRST;
          rem_nxt   = '0;
          root_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      CS_SQRT: begin
        rem_nxt  = ge ? diff[49:0] : sub_a[49:0];
        root_nxt = {root_r[ACC_W-2:0], ge};
        prod_nxt = {prod_r[PROD_W-3:0], 2'b00};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (root_nxt == '0) begin
            state_nxt = CS_FIN;
          end else begin
            state_nxt = CS_DIV;
            cnt_nxt   = DIV_FIRST;
            rem_nxt   = '0;
            dvd_nxt   = {mag, 15'b0};
            neg_nxt   = dot[ACC_W-1];
            q_nxt     = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      CS_DIV: begin
        rem_nxt = ge ? {2'b0, diff[ACC_W-1:0]} : {2'b0, sub_a[ACC_W-1:0]};
        q_nxt   = {q_r[14:0], ge};
        ovf_nxt = ovf_r | q_r[15];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = CS_FIN;
        end
      end
      CS_FIN: begin
        if (root_r == '0) begin
          sim_nxt = '0;
        end else if (neg_r) begin
          sim_nxt = (ovf_r || (q_r[15] && (q_r[14:0] != '0))) ? SIM_MIN : 16'(16'd0 - q_r);
        end else begin
          sim_nxt = (ovf_r || q_r[15]) ? SIM_MAX : q_r;
        end
        state_nxt = CS_DONE;
      end
      CS_DONE: begin
        if (ctl.ack) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  assign sts.done = (state_r == CS_DONE);
  assign sts.sim  = sim_r;

endmodule

// ===== hdl/cosine_similarity_engine_core.sv =====
// Throughput: one element pair per cycle while a vector streams in.
// After the transfer of the last pair the result is computed in 4 partial-product steps,
// 48 root steps and 63 quotient steps (root and quotient steps share one subtractor);
// the quotient steps are skipped when the denominator is zero. No pair is taken meanwhile.
// Reset (synchronous, rst_n low) clears the accumulators and all valid state.
`timescale 1ns / 1ps

module cosine_similarity_engine_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_a_value,
  input  logic signed [15:0] in_b_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_similarity
);
  import csim_pkg::*;

  top_state_t        state_r, state_nxt;
  logic              prod_vld_r;
  logic              prod_last_r;
  logic signed [31:0] p_ab_r;
  logic [31:0]       p_aa_r, p_bb_r;
  logic signed [31:0] p_aa_s, p_bb_s;
  logic [ACC_W-1:0]  dot_sum_r, dot_sum_nxt;
  logic [ACC_W-1:0]  norm_a_r, norm_a_nxt;
  logic [ACC_W-1:0]  norm_b_r, norm_b_nxt;
  logic [ACC_W:0]    dot_ext, na_ext, nb_ext;
  logic              out_vld_r;
  logic [15:0]       out_sim_r;
  logic              in_xfer, out_free, acc_last;
  calc_ctl_t         ctl;
  calc_sts_t         sts;

  assign in_stall = (state_r != ST_ACC) || (prod_vld_r && prod_last_r);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;
  assign acc_last = (state_r == ST_ACC) && prod_vld_r && prod_last_r;

  assign ctl.start = acc_last;
  assign ctl.ack   = (state_r == ST_CALC) && sts.done && out_free;

  assign p_aa_s = in_a_value * in_a_value;
  assign p_bb_s = in_b_value * in_b_value;

  assign dot_ext = {dot_sum_r[ACC_W-1], dot_sum_r} + {{(ACC_W-31){p_ab_r[31]}}, p_ab_r};
  assign na_ext  = {1'b0, norm_a_r} + {{(ACC_W-31){1'b0}}, p_aa_r};
  assign nb_ext  = {1'b0, norm_b_r} + {{(ACC_W-31){1'b0}}, p_bb_r};

  always_comb begin
    dot_sum_nxt = dot_sum_r;
    norm_a_nxt  = norm_a_r;
    norm_b_nxt  = norm_b_r;
    state_nxt   = state_r;
    unique case (state_r)
      ST_ACC: begin
        if (prod_vld_r) begin
          if (dot_ext[ACC_W] != dot_ext[ACC_W-1]) begin
            dot_sum_nxt = dot_ext[ACC_W] ? DOT_MIN : DOT_MAX;
          end else begin
            dot_sum_nxt = dot_ext[ACC_W-1:0];
          end
          norm_a_nxt = na_ext[ACC_W-1] ? NORM_MAX : na_ext[ACC_W-1:0];
          norm_b_nxt = nb_ext[ACC_W-1] ? NORM_MAX : nb_ext[ACC_W-1:0];
          if (prod_last_r) begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (ctl.ack) begin
          dot_sum_nxt = '0;
          norm_a_nxt  = '0;
          norm_b_nxt  = '0;
          state_nxt   = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_ACC;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      dot_sum_r  <= '0;
      norm_a_r   <= '0;
      norm_b_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      prod_vld_r <= in_xfer;
      dot_sum_r  <= dot_sum_nxt;
      norm_a_r   <= norm_a_nxt;
      norm_b_r   <= norm_b_nxt;
      if (ctl.ack) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      p_ab_r      <= in_a_value * in_b_value;
      p_aa_r      <= 32'(p_aa_s);
      p_bb_r      <= 32'(p_bb_s);
      prod_last_r <= in_last;
    end
    if (ctl.ack) begin
      out_sim_r <= sts.sim;
    end
  end

  csim_calc u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .norm_a (norm_a_r),
    .norm_b (norm_b_r),
    .dot    ($signed(dot_sum_r)),
    .sts    (sts)
  );

  assign out_valid      = out_vld_r;
  assign out_similarity = $signed(out_sim_r);

  a_stall_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> in_stall)
    else $error("pair taken while result is being computed");

  a_out_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == ST_CALC))
    else $error("result raised outside of calculation");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ack |=> (dot_sum_r == '0) && (norm_a_r == '0) && (norm_b_r == '0))
    else $error("accumulators not cleared after result");

  a_no_prod_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> !prod_vld_r)
    else $error("product stage busy during calculation");

endmodule
